/* src/ncx_pkg.sv */
// ----------------------------------------------------------------------------
// ncx_pkg
// Shared types and codes for the nonzero coordinate extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package ncx_pkg;

    // one coordinate / dimension extent
    typedef logic [15:0] coord_t;
    // saturating hit count
    typedef logic [62:0] count_t;

    localparam int unsigned NUM_COORDS = 4;

    localparam count_t CNT_MAX = {63{1'b1}};

    // configuration register indexes
    localparam logic [2:0] REG_NUM_DIMS  = 3'd0;
    localparam logic [2:0] REG_SIZE_DIM0 = 3'd1;
    localparam logic [2:0] REG_SIZE_DIM1 = 3'd2;
    localparam logic [2:0] REG_SIZE_DIM2 = 3'd3;
    localparam logic [2:0] REG_SIZE_DIM3 = 3'd4;
    localparam logic [2:0] REG_ELEM_FMT  = 3'd5;

    // element formats
    localparam logic [2:0] FMT_INT     = 3'd0;
    localparam logic [2:0] FMT_HALF    = 3'd1;
    localparam logic [2:0] FMT_BF16    = 3'd2;
    localparam logic [2:0] FMT_FP32    = 3'd3;
    localparam logic [2:0] FMT_FP64    = 3'd4;
    localparam logic [2:0] FMT_CPLX32  = 3'd5;

endpackage : ncx_pkg

`default_nettype wire

/* src/ncx_nonzero_test.sv */
// ----------------------------------------------------------------------------
// ncx_nonzero_test
// Format-dependent nonzero test of one raw element; sign bits are ignored
// for floating formats.
// ----------------------------------------------------------------------------
`default_nettype none

module ncx_nonzero_test
    import ncx_pkg::*;
(
    input  wire logic [63:0] element_bits,
    input  wire logic [2:0]  element_format,
    output logic             nonzero
);

    always_comb begin
        case (element_format) inside
            FMT_HALF, FMT_BF16: nonzero = |element_bits[14:0];
            FMT_FP32:           nonzero = |element_bits[30:0];
            FMT_FP64:           nonzero = |element_bits[62:0];
            FMT_CPLX32:         nonzero = (|element_bits[30:0]) | (|element_bits[62:32]);
            default:            nonzero = |element_bits;
        endcase
    end

endmodule : ncx_nonzero_test

`default_nettype wire

/* src/ncx_odometer.sv */
// ----------------------------------------------------------------------------
// ncx_odometer
// Running multi-dimensional index; innermost used dimension moves fastest.
// ----------------------------------------------------------------------------
`default_nettype none

module ncx_odometer
    import ncx_pkg::*;
#(
    parameter int unsigned MAX_DIMS = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       advance,
    input  wire logic [2:0]                 dims_used,
    input  wire coord_t [NUM_COORDS-1:0]    size_dim,
    output coord_t [NUM_COORDS-1:0]         coord,
    output logic                            last
);

    coord_t [MAX_DIMS-1:0] pos_reg;
    coord_t [MAX_DIMS-1:0] pos_next;
    logic   [MAX_DIMS-1:0] used;
    logic   [MAX_DIMS-1:0] wrap;
    logic   [MAX_DIMS-1:0] carry_in;
    logic   [MAX_DIMS-1:0][16:0] pos_inc;

    always_comb begin
        logic   carry;
        coord_t sz;
        carry = 1'b1;
        for (int d = MAX_DIMS - 1; d >= 0; d--) begin
            used[d]    = 3'(d) < dims_used;
            sz         = (size_dim[d] == '0) ? 16'd1 : size_dim[d];
            pos_inc[d] = {1'b0, pos_reg[d]} + 17'd1;
            wrap[d]    = pos_inc[d] >= {1'b0, sz};
            carry_in[d] = carry;
            carry      = carry & (~used[d] | wrap[d]);
        end
        last = carry;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (!used[d]) begin
                pos_next[d] = '0;
            end else if (carry_in[d]) begin
                pos_next[d] = wrap[d] ? '0 : pos_inc[d][15:0];
            end else begin
                pos_next[d] = pos_reg[d];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (advance) begin
            pos_reg <= pos_next;
        end
    end

    for (genvar i = 0; i < NUM_COORDS; i++) begin : g_coord
        if (i < MAX_DIMS) begin : g_live
            assign coord[i] = used[i] ? pos_reg[i] : '0;
        end else begin : g_dead
            assign coord[i] = '0;
        end
    end

endmodule : ncx_odometer

`default_nettype wire

/* src/nonzero_coordinate_extractor.sv */
// ----------------------------------------------------------------------------
// nonzero_coordinate_extractor
// Streams tensor elements in row-major order and reports, per element, the
// nonzero flag, its coordinates, its output row and the running hit count.
// ----------------------------------------------------------------------------
// One result per element, one element per clock sustained while m_ready
// holds. An element is held in the input register, then the nonzero test,
// odometer carry and the 63-bit saturating count settle combinationally
// into the result register, and result valid is registered there. While a
// result waits, one more element can enter the input register; after that
// the input side takes an element only in a cycle in which the result
// transfers. Coordinates of unused dimensions read 0, num_dims 0 is a
// scalar (every element is the last), a zero size acts as 1. The element
// that wraps the outermost dimension raises tensor_done and clears the
// odometer and hit count. Configuration writes take effect at once and
// must only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nonzero_coordinate_extractor
    import ncx_pkg::*;
#(
    parameter int unsigned MAX_DIMS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // element input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_element_bits,
    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit,
    output logic [15:0]      m_coord_a,
    output logic [15:0]      m_coord_b,
    output logic [15:0]      m_coord_c,
    output logic [15:0]      m_coord_d,
    output logic [62:0]      m_row_index,
    output logic [62:0]      m_hits_so_far,
    output logic             m_tensor_done
);

    localparam logic [2:0] MaxDimsW = 3'(MAX_DIMS);

    // ---------------- configuration registers ----------------
    logic [2:0]                    num_dims_reg;
    coord_t [NUM_COORDS-1:0]       size_dim_reg;
    logic [2:0]                    elem_fmt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg <= 3'd1;
            size_dim_reg <= {NUM_COORDS{16'd1}};
            elem_fmt_reg <= FMT_INT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NUM_DIMS:  num_dims_reg    <= cfg_wdata[2:0];
                REG_SIZE_DIM0: size_dim_reg[0] <= cfg_wdata;
                REG_SIZE_DIM1: size_dim_reg[1] <= cfg_wdata;
                REG_SIZE_DIM2: size_dim_reg[2] <= cfg_wdata;
                REG_SIZE_DIM3: size_dim_reg[3] <= cfg_wdata;
                REG_ELEM_FMT:  elem_fmt_reg    <= cfg_wdata[2:0];
                default: ; // indexes past the register list are dropped
            endcase
        end
    end

    // clamp to what the odometer actually holds
    logic [2:0] dims_used;
    assign dims_used = (num_dims_reg > MaxDimsW) ? MaxDimsW : num_dims_reg;

    // ---------------- input register ----------------
    logic        in_valid_reg;
    logic [63:0] in_bits_reg;
    logic        advance;   // element moves from input to result register

    assign advance = in_valid_reg & (~m_valid | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_bits_reg <= s_element_bits;
        end
    end

    // ---------------- element processing ----------------
    logic                    nonzero;
    coord_t [NUM_COORDS-1:0] coord;
    logic                    last;

    ncx_nonzero_test u_nonzero (
        .element_bits   (in_bits_reg),
        .element_format (elem_fmt_reg),
        .nonzero        (nonzero)
    );

    ncx_odometer #(
        .MAX_DIMS (MAX_DIMS)
    ) u_odometer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .dims_used (dims_used),
        .size_dim  (size_dim_reg),
        .coord     (coord),
        .last      (last)
    );

    // saturating hit count; cleared after the last element of a tensor
    count_t hit_total_reg;
    count_t hit_total_next;
    count_t hits_after;

    assign hits_after = (nonzero && hit_total_reg != CNT_MAX) ? hit_total_reg + 63'd1
                                                              : hit_total_reg;
    assign hit_total_next = last ? '0 : hits_after;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_total_reg <= '0;
        end else if (advance) begin
            hit_total_reg <= hit_total_next;
        end
    end

    // ---------------- result register ----------------
    logic   m_valid_reg;
    logic   m_hit_reg;
    coord_t m_coord_a_reg;
    coord_t m_coord_b_reg;
    coord_t m_coord_c_reg;
    coord_t m_coord_d_reg;
    count_t m_row_index_reg;
    count_t m_hits_so_far_reg;
    logic   m_tensor_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_hit_reg         <= nonzero;
            m_coord_a_reg     <= coord[0];
            m_coord_b_reg     <= coord[1];
            m_coord_c_reg     <= coord[2];
            m_coord_d_reg     <= coord[3];
            m_row_index_reg   <= nonzero ? hit_total_reg : '0;  // no row without a hit
            m_hits_so_far_reg <= hits_after;
            m_tensor_done_reg <= last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_coord_a     = m_coord_a_reg;
    assign m_coord_b     = m_coord_b_reg;
    assign m_coord_c     = m_coord_c_reg;
    assign m_coord_d     = m_coord_d_reg;
    assign m_row_index   = m_row_index_reg;
    assign m_hits_so_far = m_hits_so_far_reg;
    assign m_tensor_done = m_tensor_done_reg;

endmodule : nonzero_coordinate_extractor

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nonzero coordinate extractor: streams elements
// over a range of shapes and element formats and checks every result
// against an in-bench odometer and hit counter.
// ----------------------------------------------------------------------------

module tb_top;
    import ncx_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int MAX_DIMS         = 4;
    localparam int RANDOM_ITEMS     = 360;
    localparam int CALM_TAIL        = 100;   // last random items run with no idling
    localparam int LONG_HOLD_CYCLES = 64;    // receiver hold-off that fills the block
    localparam int DRAIN_CYCLES     = 4;     // margin after the result queue drains
    // Longest honest quiet stretch is the long hold-off plus a burst and a
    // handful of config writes.
    localparam int WATCHDOG_LIMIT   = 2000;

    // indexes past the register list; writes to them must be dropped
    localparam logic [2:0] REG_SPARE6 = 3'd6;
    localparam logic [2:0] REG_SPARE7 = 3'd7;
    // format codes past the list; these behave as int/bool
    localparam logic [2:0] FMT_SPARE6 = 3'd6;
    localparam logic [2:0] FMT_SPARE7 = 3'd7;

    typedef struct packed {
        logic   hit;
        coord_t coord_a;
        coord_t coord_b;
        coord_t coord_c;
        coord_t coord_d;
        count_t row_index;
        count_t hits_so_far;
        logic   tensor_done;
    } coord_result_t;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_element_bits;
    logic        m_valid;
    logic        m_ready;
    logic        m_hit;
    logic [15:0] m_coord_a;
    logic [15:0] m_coord_b;
    logic [15:0] m_coord_c;
    logic [15:0] m_coord_d;
    logic [62:0] m_row_index;
    logic [62:0] m_hits_so_far;
    logic        m_tensor_done;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // mirror of the configuration registers
    logic [2:0]    cfg_num_dims;
    coord_t        cfg_extent [NUM_COORDS];
    logic [2:0]    cfg_format;
    // mirror of the odometer and running hit count
    coord_t        odo_pos [NUM_COORDS];
    count_t        nz_total;

    coord_result_t coord_expect_q [$];

    int            mismatch_count = 0;
    int            sent_count     = 0;
    int            quiet_cycles   = 0;
    bit            tx_idle_on;
    bit            rx_idle_on;
    bit            long_hold_req;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    nonzero_coordinate_extractor #(
        .MAX_DIMS(MAX_DIMS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_element_bits(s_element_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_coord_a     (m_coord_a),
        .m_coord_b     (m_coord_b),
        .m_coord_c     (m_coord_c),
        .m_coord_d     (m_coord_d),
        .m_row_index   (m_row_index),
        .m_hits_so_far (m_hits_so_far),
        .m_tensor_done (m_tensor_done)
    );

    // ------------------------------------------------------------------------
    // Predictor: one call per accepted element. Coordinates are reported from
    // the odometer before it advances; the innermost used dimension steps
    // first and a carry out of the outermost marks the last element, which
    // clears both the odometer and the count.
    // ------------------------------------------------------------------------
    function automatic void predict_coordinates(input logic [63:0] bits);
        coord_result_t r;
        int            nd;
        int            d;
        logic          nz;
        logic          carry;
        logic [16:0]   extent;
        count_t        after;
        nd = (cfg_num_dims > MAX_DIMS) ? MAX_DIMS : int'(cfg_num_dims);
        // floating formats drop the sign bit, so -0 is zero and NaN is not
        case (cfg_format)
            FMT_HALF, FMT_BF16: nz = |bits[14:0];
            FMT_FP32:           nz = |bits[30:0];
            FMT_FP64:           nz = |bits[62:0];
            FMT_CPLX32:         nz = (|bits[62:32]) | (|bits[30:0]);
            default:            nz = |bits;
        endcase
        r.hit         = nz;
        r.coord_a     = (nd > 0) ? odo_pos[0] : '0;
        r.coord_b     = (nd > 1) ? odo_pos[1] : '0;
        r.coord_c     = (nd > 2) ? odo_pos[2] : '0;
        r.coord_d     = (nd > 3) ? odo_pos[3] : '0;
        // saturation at the top of 63 bits is out of reach in any real run
        after         = (nz && nz_total != CNT_MAX) ? nz_total + 63'd1 : nz_total;
        r.row_index   = nz ? nz_total : '0;
        r.hits_so_far = after;
        carry = 1'b1;
        for (d = nd - 1; d >= 0; d--) begin
            if (carry) begin
                // zero extent acts as one; a position left past a shrunk
                // extent wraps to zero with a carry
                extent = (cfg_extent[d] == '0) ? 17'd1 : {1'b0, cfg_extent[d]};
                if ({1'b0, odo_pos[d]} + 17'd1 < extent) begin
                    odo_pos[d] = odo_pos[d] + 16'd1;
                    carry      = 1'b0;
                end else begin
                    odo_pos[d] = '0;
                end
            end
        end
        for (d = nd; d < NUM_COORDS; d++) odo_pos[d] = '0;
        r.tensor_done = carry;
        if (carry) begin
            foreach (odo_pos[i]) odo_pos[i] = '0;
            nz_total = '0;
        end else begin
            nz_total = after;
        end
        coord_expect_q = {coord_expect_q, r};
    endfunction

    // ------------------------------------------------------------------------
    // Element source helpers
    // ------------------------------------------------------------------------
    // zeros, single bits and sign-only words show up far more often than a
    // plain 64-bit draw would give them
    function automatic logic [63:0] random_element();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = 64'd1 << $urandom_range(0, 63);
            2: begin
                case ($urandom_range(0, 3))
                    0:       v = 64'h0000_0000_0000_8000;
                    1:       v = 64'h0000_0000_8000_0000;
                    2:       v = 64'h8000_0000_0000_0000;
                    default: v = 64'h8000_0000_8000_0000;
                endcase
            end
            3: v = {$urandom, 32'h0};
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic coord_t random_extent();
        coord_t e;
        case ($urandom_range(0, 15))
            0:       e = '0;
            1:       e = 16'hFFFF;
            2:       e = coord_t'($urandom_range(5, 65535));
            default: e = coord_t'($urandom_range(1, 4));
        endcase
        return e;
    endfunction

    // One element transfer. Valid is left high on return so back-to-back
    // elements keep it asserted; it only drops in an idle burst or a drain.
    task automatic send_element(input logic [63:0] bits);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_element_bits <= bits;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_coordinates(bits);
        sent_count++;
    endtask

    // sender pause: nothing offered until every expected result is back
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (coord_expect_q.size() != 0) @(posedge aclk);
    endtask

    // register write; only called with the block idle
    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (index)
            REG_NUM_DIMS:  cfg_num_dims  = value[2:0];
            REG_SIZE_DIM0: cfg_extent[0] = value;
            REG_SIZE_DIM1: cfg_extent[1] = value;
            REG_SIZE_DIM2: cfg_extent[2] = value;
            REG_SIZE_DIM3: cfg_extent[3] = value;
            REG_ELEM_FMT:  cfg_format    = value[2:0];
            default: ;     // spare indexes are dropped by the block
        endcase
    endtask

    task automatic load_config(input logic [2:0] nd, input coord_t e0, input coord_t e1,
                               input coord_t e2, input coord_t e3, input logic [2:0] fmt);
        write_reg(REG_NUM_DIMS, {13'd0, nd});
        write_reg(REG_SIZE_DIM0, e0);
        write_reg(REG_SIZE_DIM1, e1);
        write_reg(REG_SIZE_DIM2, e2);
        write_reg(REG_SIZE_DIM3, e3);
        write_reg(REG_ELEM_FMT, {13'd0, fmt});
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset shape is one dim of extent one: every element closes a tensor
    task automatic test_reset_defaults();
        send_element('0);
        send_element('1);
        send_element(64'h8000_0000_0000_0000);
        wait_results_drained();
    endtask

    // each format sees its own negative zero (no hit) and a word that is
    // zero only in the low half (hit for int, fp64 and complex)
    task automatic test_element_formats();
        logic [2:0]  fmt;
        logic [63:0] neg_zero;
        load_config(3'd2, 16'd4, 16'd4, 16'd1, 16'd1, FMT_INT);
        for (int i = 0; i < 8; i++) begin
            fmt = i[2:0];
            write_reg(REG_ELEM_FMT, {13'd0, fmt});
            case (fmt)
                FMT_HALF, FMT_BF16: neg_zero = 64'h0000_0000_0000_8000;
                FMT_FP32:           neg_zero = 64'h0000_0000_8000_0000;
                FMT_FP64:           neg_zero = 64'h8000_0000_0000_0000;
                FMT_CPLX32:         neg_zero = 64'h8000_0000_8000_0000;
                default:            neg_zero = '0;
            endcase
            send_element(neg_zero);
            send_element(64'h7FFF_FFFF_0000_0000);
            wait_results_drained();
        end
    endtask

    // zero dims: coordinates all zero, every element is the last
    task automatic test_scalar();
        load_config(3'd0, 16'd3, 16'd3, 16'd3, 16'd3, FMT_FP32);
        send_element(64'h0000_0000_3F80_0000);
        send_element(64'h0000_0000_8000_0000);
        send_element('1);
        wait_results_drained();
    endtask

    // shrink an extent under a live position, write the spare indexes, then
    // ask for more dims than the block has with a zero extent in the mix
    task automatic test_resize_mid_tensor();
        load_config(3'd2, 16'd4, 16'd5, 16'd1, 16'd1, FMT_INT);
        repeat (8) send_element(random_element());
        wait_results_drained();
        write_reg(REG_SIZE_DIM1, 16'd2);
        write_reg(REG_SPARE6, 16'hFFFF);
        write_reg(REG_SPARE7, 16'hFFFF);
        repeat (10) send_element(random_element());
        wait_results_drained();
        write_reg(REG_NUM_DIMS, 16'd7);
        write_reg(REG_SIZE_DIM2, 16'd0);
        write_reg(REG_SIZE_DIM3, 16'd3);
        write_reg(REG_ELEM_FMT, {13'd0, FMT_SPARE7});
        repeat (12) send_element(random_element());
        wait_results_drained();
        write_reg(REG_NUM_DIMS, 16'd5);
        write_reg(REG_ELEM_FMT, {13'd0, FMT_SPARE6});
        repeat (12) send_element(random_element());
        wait_results_drained();
    endtask

    // largest extents on all four dims, then collapse the innermost so the
    // stored position overruns it and carries into the next one
    task automatic test_wide_extents();
        load_config(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, FMT_BF16);
        repeat (40) send_element(random_element());
        wait_results_drained();
        write_reg(REG_SIZE_DIM3, 16'd1);
        repeat (6) send_element(random_element());
        wait_results_drained();
    endtask

    // receiver holds off long enough that the block backs up into s_ready
    task automatic test_backpressure();
        load_config(3'd3, 16'd2, 16'd3, 16'd4, 16'd1, FMT_CPLX32);
        tx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        repeat (24) send_element(random_element());
        wait_results_drained();
        tx_idle_on = 1'b1;
    endtask

    // Mostly whole tensors of small random shape with random content; some
    // phases stop short or run over so the next shape starts mid-tensor.
    task automatic test_random_tensors();
        int       start;
        int       nd;
        int       count;
        longint   elems;
        coord_t   ext [NUM_COORDS];
        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS) begin
            wait_results_drained();
            nd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            foreach (ext[i]) ext[i] = random_extent();
            load_config(nd[2:0], ext[0], ext[1], ext[2], ext[3],
                        3'($urandom_range(0, 7)));
            elems = 1;
            for (int d = 0; d < nd && d < MAX_DIMS; d++)
                elems *= (ext[d] == '0) ? 1 : longint'(ext[d]);
            if (elems > 64)
                count = $urandom_range(4, 48);
            else if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, int'(elems));
            else
                count = int'(elems) * $urandom_range(1, 2);
            // a phase that reaches into the tail runs without idling
            if (sent_count - start + count > RANDOM_ITEMS - CALM_TAIL) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            repeat (count) send_element(random_element());
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge aclk);
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: each transfer against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        coord_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (coord_expect_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual hit %0b coord %0d/%0d/%0d/%0d",
                         $time, m_hit, m_coord_a, m_coord_b, m_coord_c, m_coord_d);
                mismatch_count++;
            end else begin
                want = coord_expect_q.pop_front();
                check_field("hit", 64'(want.hit), 64'(m_hit));
                check_field("coord_a", 64'(want.coord_a), 64'(m_coord_a));
                check_field("coord_b", 64'(want.coord_b), 64'(m_coord_b));
                check_field("coord_c", 64'(want.coord_c), 64'(m_coord_c));
                check_field("coord_d", 64'(want.coord_d), 64'(m_coord_d));
                check_field("row_index", 64'(want.row_index), 64'(m_row_index));
                check_field("hits_so_far", 64'(want.hits_so_far), 64'(m_hits_so_far));
                check_field("tensor_done", 64'(want.tensor_done), 64'(m_tensor_done));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no transfer on either side
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_NUM_DIMS;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_element_bits = '0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        long_hold_req  = 1'b0;
        // register and state values after reset
        cfg_num_dims   = 3'd1;
        foreach (cfg_extent[i]) cfg_extent[i] = 16'd1;
        cfg_format     = FMT_INT;
        foreach (odo_pos[i]) odo_pos[i] = '0;
        nz_total       = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_element_formats();
        test_scalar();
        test_resize_mid_tensor();
        test_wide_extents();
        test_backpressure();
        test_random_tensors();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && coord_expect_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
